@@ sv/frm_pkg.sv @@
// Shared types and constants for the three-channel frame rate meter.
// Used by frm_apb_regs, frm_lane and three_channel_frame_rate_meter_unit.
package frm_pkg;

    localparam int NCH = 3;

    localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
    localparam logic [15:0] RATE_MAX     = 16'hFFFF;
    localparam logic [31:0] WINDOW_RESET = 32'd1000000;

    // register index codes (byte address bit 2)
    localparam logic REG_WINDOW = 1'b0;

    typedef struct packed {
        logic [62:0] time_us;
        logic        link_up;
        logic        session_on;
        logic [31:0] video_out_count;
        logic [31:0] audio_out_count;
        logic [31:0] audio_in_count;
    } t_in_item;

    typedef struct packed {
        logic [15:0] video_out_rate;
        logic [15:0] audio_out_rate;
        logic [15:0] audio_in_rate;
    } t_out_item;

    typedef struct packed {
        logic        done;
        logic [15:0] rate;
    } t_lane_res;

endpackage

@@ sv/frm_apb_regs.sv @@
// APB register block of the frame rate meter: holds the window length.
// Depends on frm_pkg for the register code and reset value.
module frm_apb_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [31:0] o_window
);

    logic [31:0] r_window;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= frm_pkg::WINDOW_RESET;
        end else if (psel && penable && pwrite && paddr[2] == frm_pkg::REG_WINDOW) begin
            r_window <= pwdata;
        end
    end

    assign prdata   = (paddr[2] == frm_pkg::REG_WINDOW) ? r_window : 32'd0;
    assign pready   = 1'b1;
    assign o_window = r_window;

endmodule

@@ sv/frm_lane.sv @@
// One rate lane: rate = (delta*1e6 + elapsed/2) / elapsed, saturated to 16 bits.
// Multiply, add, saturation check, then 16 restoring division steps. Uses frm_pkg.
module frm_lane (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [31:0]          i_delta,
    input  logic [62:0]          i_elapsed,
    output frm_pkg::t_lane_res   o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_CHK,
        S_DIV
    } t_state;

    t_state      r_state;
    logic [31:0] r_delta;
    logic [62:0] r_elapsed;
    logic [51:0] r_prod;
    logic [63:0] r_rem;
    logic [77:0] r_div;
    logic [15:0] r_q;
    logic [3:0]  r_cnt;
    logic        r_sat;
    logic        r_done;

    logic        w_fit;

    // remainder stays below 2^64, so a divisor at or above that never fits
    assign w_fit = {14'd0, r_rem} >= r_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == S_DIV) && (r_cnt == 4'd0);
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_delta   <= i_delta;
                        r_elapsed <= i_elapsed;
                        r_state   <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= 52'(r_delta) * 52'(frm_pkg::USEC_PER_SEC);
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_rem   <= 64'(r_prod) + 64'(r_elapsed[62:1]);
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    // flag a quotient that would not fit in 16 bits, but run the
                    // division steps anyway so every lane finishes in the same cycle
                    r_sat   <= {16'd0, r_rem} >= {1'b0, r_elapsed, 16'd0};
                    r_div   <= {r_elapsed, 15'd0};
                    r_q     <= 16'd0;
                    r_cnt   <= 4'd15;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_fit) begin
                        r_rem <= r_rem - r_div[63:0];
                    end
                    r_q   <= {r_q[14:0], w_fit};
                    r_div <= r_div >> 1;
                    r_cnt <= r_cnt - 4'd1;
                    if (r_cnt == 4'd0) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.done = r_done;
    assign o_res.rate = r_sat ? frm_pkg::RATE_MAX : r_q;

endmodule

@@ sv/three_channel_frame_rate_meter_unit.sv @@
// Three-channel frame rate meter: top level with sample control and result merge.
// Depends on frm_pkg, frm_apb_regs and frm_lane.
//
// One status sample is taken at a time; the input stalls from acceptance until
// the result has been loaded into the output register. A sample that needs a
// rate computation goes through evaluation, lane set-up (multiply, round,
// saturation check), 16 restoring division steps in each of the three parallel
// lanes, the merge and the output load; the next sample is taken in idle.
// A saturated rate runs the same steps so the lanes stay in step. Samples that
// only clear, rebase or keep the rates go from evaluation straight to the
// output load. A result still waiting at the output holds the next sample back
// for as long as the output stays stalled.
module three_channel_frame_rate_meter_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  frm_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output frm_pkg::t_out_item  o_out_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_WAIT,
        S_EMIT
    } t_state;

    t_state              r_state;
    frm_pkg::t_in_item   r_item;
    logic [31:0]         r_base_cnt [frm_pkg::NCH];
    logic [15:0]         r_held     [frm_pkg::NCH];
    logic [62:0]         r_base_time;
    logic                r_rebase;
    logic                r_out_valid;
    frm_pkg::t_out_item  r_out_item;

    logic [31:0]         w_window;
    logic [31:0]         w_cnt   [frm_pkg::NCH];
    logic [31:0]         w_delta [frm_pkg::NCH];
    frm_pkg::t_lane_res  w_res   [frm_pkg::NCH];
    logic [frm_pkg::NCH-1:0] w_done;
    logic [62:0]         w_elapsed;
    logic                w_active;
    logic                w_no_base;
    logic                w_win;
    logic                w_any;
    logic                w_start;

    frm_apb_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_window (w_window)
    );

    assign w_cnt[0] = r_item.video_out_count;
    assign w_cnt[1] = r_item.audio_out_count;
    assign w_cnt[2] = r_item.audio_in_count;

    assign w_active  = r_item.link_up && r_item.session_on;
    assign w_no_base = (r_base_time == 63'd0) || (r_item.time_us <= r_base_time);
    assign w_elapsed = r_item.time_us - r_base_time;
    assign w_win     = w_elapsed >= 63'(w_window);

    always_comb begin
        w_any = 1'b0;
        for (int i = 0; i < frm_pkg::NCH; i++) begin
            w_delta[i] = w_cnt[i] - r_base_cnt[i];
            w_any      = w_any | (w_delta[i] != 32'd0);
        end
    end

    assign w_start = (r_state == S_EVAL) && w_active && !w_no_base && (w_win || w_any);

    for (genvar g = 0; g < frm_pkg::NCH; g++) begin : g_lane
        frm_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_start   (w_start),
            .i_delta   (w_delta[g]),
            .i_elapsed (w_elapsed),
            .o_res     (w_res[g])
        );
        assign w_done[g] = w_res[g].done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_rebase    <= 1'b0;
            r_base_time <= 63'd0;
            for (int i = 0; i < frm_pkg::NCH; i++) begin
                r_base_cnt[i] <= 32'd0;
                r_held[i]     <= 16'd0;
            end
        end else begin
            // drop the result once taken, unless a new one replaces it
            if (r_out_valid && !i_out_stall && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in_item;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (!w_active || w_no_base) begin
                        // clear on an inactive sample, then store the baseline
                        if (!w_active) begin
                            for (int i = 0; i < frm_pkg::NCH; i++) begin
                                r_held[i] <= 16'd0;
                            end
                        end
                        for (int i = 0; i < frm_pkg::NCH; i++) begin
                            r_base_cnt[i] <= w_cnt[i];
                        end
                        r_base_time <= r_item.time_us;
                        r_state     <= S_EMIT;
                    end else if (w_start) begin
                        r_rebase <= w_win;
                        r_state  <= S_WAIT;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_WAIT: begin
                    // merge: the lanes run in lock step
                    if (&w_done) begin
                        for (int i = 0; i < frm_pkg::NCH; i++) begin
                            r_held[i] <= w_res[i].rate;
                        end
                        if (r_rebase) begin
                            for (int i = 0; i < frm_pkg::NCH; i++) begin
                                r_base_cnt[i] <= w_cnt[i];
                            end
                            r_base_time <= r_item.time_us;
                        end
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_item.video_out_rate <= r_held[0];
                        r_out_item.audio_out_rate <= r_held[1];
                        r_out_item.audio_in_rate  <= r_held[2];
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTH
    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|w_done) |-> (&w_done))
        else $error("rate lanes finished out of step");

    a_done_only_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|w_done) |-> (r_state == S_WAIT))
        else $error("lane result with no request waiting");

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_EMIT))
        else $error("result raised outside the emit step");

    a_inactive_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !(r_item.link_up && r_item.session_on)) |->
        (r_held[0] == 16'd0 && r_held[1] == 16'd0 && r_held[2] == 16'd0))
        else $error("rates not cleared on an inactive request");
`endif

endmodule
